// File: hw/rtl/feab_pkg.sv
// Shared types, register indexes and constants of the feathered edge alpha blend core.
package feab_pkg;

  localparam int MAX_SIDE    = 1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STEPS   = 16;
  localparam int BACK_STAGES = DIV_STEPS + 4;
  localparam int DEN_SCALE   = 25500;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int SIZE_W      = 11;
  localparam int COORD_W     = 10;
  localparam int PCT_W       = 7;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int DEN_W       = 26;
  localparam int PROD_W      = SIZE_W + CH_W;
  localparam int WGT_W       = DIV_STEPS + 1;
  localparam int PCT_MAX     = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_PERCENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CH0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CH1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CH2    = 3'd6;

  typedef struct packed {
    logic [SIZE_W-1:0] border_width;
    logic [PCT_W-1:0]  blend_percent;
    logic [SIZE_W-1:0] patch_width;
    logic [SIZE_W-1:0] patch_height;
    logic [CH_W-1:0]   target_ch0;
    logic [CH_W-1:0]   target_ch1;
    logic [CH_W-1:0]   target_ch2;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] ramp;
    logic [SIZE_W-1:0] bw;
    logic [CH_W-1:0]   alpha;
    logic [PIX_W-1:0]  pix;
  } entry_t;

endpackage

// File: hw/rtl/feab_front.sv
// Front end: takes pixel items, finds edge distance and ramp, registers the queue entry.
module feab_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [feab_pkg::COORD_W-1:0]        in_row,
  input  logic [feab_pkg::COORD_W-1:0]        in_col,
  input  logic [feab_pkg::PIX_W-1:0]          in_pix,
  input  logic [feab_pkg::CH_W-1:0]           in_alpha,
  input  feab_pkg::cfg_t                      cfg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output feab_pkg::entry_t                    out_entry
);

  logic                              valid_r;
  feab_pkg::entry_t                  entry_r;
  feab_pkg::entry_t                  entry_nxt;
  logic [feab_pkg::SIZE_W-1:0]       bw;
  logic [feab_pkg::SIZE_W-1:0]       row_x;
  logic [feab_pkg::SIZE_W-1:0]       col_x;
  logic [feab_pkg::SIZE_W-1:0]       d_bot;
  logic [feab_pkg::SIZE_W-1:0]       d_rt;
  logic [feab_pkg::SIZE_W-1:0]       d_a;
  logic [feab_pkg::SIZE_W-1:0]       d_b;
  logic [feab_pkg::SIZE_W-1:0]       dmin;
  logic [feab_pkg::SIZE_W-1:0]       m;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_entry = entry_r;

  always_comb begin
    bw    = (cfg.border_width == '0) ? feab_pkg::SIZE_W'(1) : cfg.border_width;
    row_x = {1'b0, in_row};
    col_x = {1'b0, in_col};
    // far-edge distance saturates to zero outside the patch
    d_bot = (row_x >= cfg.patch_height) ? '0 : cfg.patch_height - 1'b1 - row_x;
    d_rt  = (col_x >= cfg.patch_width) ? '0 : cfg.patch_width - 1'b1 - col_x;
    d_a   = (row_x < col_x) ? row_x : col_x;
    d_b   = (d_bot < d_rt) ? d_bot : d_rt;
    dmin  = (d_a < d_b) ? d_a : d_b;
    m     = (dmin < bw) ? dmin : bw;
    entry_nxt.ramp  = bw - m;
    entry_nxt.bw    = bw;
    entry_nxt.alpha = in_alpha;
    entry_nxt.pix   = in_pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// File: hw/rtl/feab_queue.sv
// Small FIFO of classified items between the front end and the blend pipeline.
module feab_queue #(
  parameter int DEPTH = feab_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  feab_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output feab_pkg::entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  feab_pkg::entry_t   mem_r [0:DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: hw/rtl/feab_back.sv
// Back end: weight product, pipelined restoring divider and per-channel mix into the output register.
module feab_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  feab_pkg::entry_t                in_entry,
  input  feab_pkg::cfg_t                  cfg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [feab_pkg::PIX_W-1:0]      out_data
);

  localparam int DS    = feab_pkg::DIV_STEPS;
  localparam int DW    = feab_pkg::DEN_W;
  localparam int WW    = feab_pkg::WGT_W;
  localparam int CW    = feab_pkg::CH_W;
  localparam int PW    = feab_pkg::PIX_W;
  localparam int ACC_W = 27;

  logic                       adv;

  logic                       s1_valid_r;
  logic [feab_pkg::PROD_W-1:0] s1_prod_r;
  logic [DW-1:0]              s1_den_r;
  logic [PW-1:0]              s1_pix_r;

  logic                       s2_valid_r;
  logic [DW-1:0]              s2_x_r;
  logic [DW-1:0]              s2_den_r;
  logic [PW-1:0]              s2_pix_r;

  logic                       dv_valid_r [0:DS];
  logic [DW-1:0]              dv_rem_r   [0:DS];
  logic [DW-1:0]              dv_den_r   [0:DS];
  logic [WW-1:0]              dv_q_r     [0:DS];
  logic [PW-1:0]              dv_pix_r   [0:DS];

  logic [DW:0]                rem2       [1:DS];
  logic                       ge         [1:DS];
  logic [DW-1:0]              rem_nxt    [1:DS];
  logic                       ge0;

  logic [PW-1:0]              tgt;
  logic signed [ACC_W-1:0]    acc        [0:2];
  logic signed [CW:0]         diff       [0:2];
  logic [PW-1:0]              mix_nxt;

  logic                       out_valid_r;
  logic [PW-1:0]              out_data_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ge0 = (s2_x_r >= s2_den_r);

  always_comb begin
    for (int k = 1; k <= DS; k++) begin
      rem2[k]    = {dv_rem_r[k-1], 1'b0};
      ge[k]      = (rem2[k] >= {1'b0, dv_den_r[k-1]});
      rem_nxt[k] = ge[k] ? DW'(rem2[k] - {1'b0, dv_den_r[k-1]}) : DW'(rem2[k]);
    end
  end

  // out = (t*65536 + w*(pix - t) + 32768) >> 16
  always_comb begin
    tgt = {cfg.target_ch2, cfg.target_ch1, cfg.target_ch0};
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({1'b0, dv_pix_r[DS][c*CW +: CW]}) - $signed({1'b0, tgt[c*CW +: CW]});
      acc[c]  = $signed({3'b0, tgt[c*CW +: CW], 16'h8000})
              + $signed({{(ACC_W-WW){1'b0}}, dv_q_r[DS]})
              * $signed({{(ACC_W-CW-1){diff[c][CW]}}, diff[c]});
      mix_nxt[c*CW +: CW] = acc[c][16 +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DS; k++) begin
        dv_valid_r[k] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_r    <= in_valid;
      s2_valid_r    <= s1_valid_r;
      dv_valid_r[0] <= s2_valid_r;
      for (int k = 1; k <= DS; k++) begin
        dv_valid_r[k] <= dv_valid_r[k-1];
      end
      out_valid_r   <= dv_valid_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r   <= feab_pkg::PROD_W'(in_entry.ramp) * feab_pkg::PROD_W'(in_entry.alpha);
      s1_den_r    <= DW'(in_entry.bw) * DW'(feab_pkg::DEN_SCALE);
      s1_pix_r    <= in_entry.pix;

      s2_x_r      <= DW'(s1_prod_r) * DW'(cfg.blend_percent);
      s2_den_r    <= s1_den_r;
      s2_pix_r    <= s1_pix_r;

      dv_rem_r[0] <= ge0 ? s2_x_r - s2_den_r : s2_x_r;
      dv_den_r[0] <= s2_den_r;
      dv_q_r[0]   <= {{(WW-1){1'b0}}, ge0};
      dv_pix_r[0] <= s2_pix_r;
      for (int k = 1; k <= DS; k++) begin
        dv_rem_r[k] <= rem_nxt[k];
        dv_den_r[k] <= dv_den_r[k-1];
        dv_q_r[k]   <= {dv_q_r[k-1][WW-2:0], ge[k]};
        dv_pix_r[k] <= dv_pix_r[k-1];
      end

      out_data_r  <= mix_nxt;
    end
  end

endmodule

// File: hw/rtl/feathered_edge_alpha_blend_core.sv
// Feathered edge alpha blend core: takes one pixel item per clock while the output is not
// stalled and returns one blended item for each, in order. Sustained rate is one item per
// clock while out_tready is held high. The restoring divider pipeline forms the Q1.16 weight.
// The front end and the blend pipeline are parted by a small queue of QUEUE_DEPTH entries;
// the back pipeline halts as a whole while its output item waits. The user is to write
// configuration through the cfg port while no item is in flight; the core does not enforce it.
module feathered_edge_alpha_blend_core #(
  parameter int QUEUE_DEPTH = feab_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pix_row[9:0], pix_col[19:10], pix_ch0[27:20], pix_ch1[35:28], pix_ch2[43:36],
  // pix_alpha[51:44], zero fill [55:52]
  input  logic [55:0]                         in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_ch0[7:0], out_ch1[15:8], out_ch2[23:16]
  output logic [23:0]                         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [feab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [feab_pkg::CFG_DATA_W-1:0]     cfg_data
);

  feab_pkg::cfg_t    cfg_r;
  feab_pkg::entry_t  fr_entry;
  feab_pkg::entry_t  q_entry;
  logic              fr_valid;
  logic              fr_ready;
  logic              q_valid;
  logic              q_ready;
  logic [feab_pkg::SIZE_W-1:0] size_clamp;
  logic [feab_pkg::PCT_W-1:0]  pct_clamp;

  assign cfg_ready = 1'b1;

  always_comb begin
    size_clamp = (int'(cfg_data) > feab_pkg::MAX_SIDE) ?
                 feab_pkg::SIZE_W'(feab_pkg::MAX_SIDE) : cfg_data;
    pct_clamp  = (int'(cfg_data[feab_pkg::PCT_W-1:0]) > feab_pkg::PCT_MAX) ?
                 feab_pkg::PCT_W'(feab_pkg::PCT_MAX) : cfg_data[feab_pkg::PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.border_width  <= feab_pkg::SIZE_W'(2);
      cfg_r.blend_percent <= feab_pkg::PCT_W'(30);
      cfg_r.patch_width   <= feab_pkg::SIZE_W'(64);
      cfg_r.patch_height  <= feab_pkg::SIZE_W'(64);
      cfg_r.target_ch0    <= '0;
      cfg_r.target_ch1    <= '0;
      cfg_r.target_ch2    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        feab_pkg::CFG_BORDER_WIDTH:  cfg_r.border_width  <= cfg_data;
        feab_pkg::CFG_BLEND_PERCENT: cfg_r.blend_percent <= pct_clamp;
        feab_pkg::CFG_PATCH_WIDTH:   cfg_r.patch_width   <= size_clamp;
        feab_pkg::CFG_PATCH_HEIGHT:  cfg_r.patch_height  <= size_clamp;
        feab_pkg::CFG_TARGET_CH0:    cfg_r.target_ch0    <= cfg_data[feab_pkg::CH_W-1:0];
        feab_pkg::CFG_TARGET_CH1:    cfg_r.target_ch1    <= cfg_data[feab_pkg::CH_W-1:0];
        feab_pkg::CFG_TARGET_CH2:    cfg_r.target_ch2    <= cfg_data[feab_pkg::CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  feab_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_row    (in_tdata[9:0]),
    .in_col    (in_tdata[19:10]),
    .in_pix    (in_tdata[43:20]),
    .in_alpha  (in_tdata[51:44]),
    .cfg       (cfg_r),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_entry (fr_entry)
  );

  feab_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_entry (fr_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  feab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_entry  (q_entry),
    .cfg       (cfg_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// File: hw/rtl/feab_checker.sv
// Port-level checks of the feathered edge alpha blend core, bound to the top level.
module feab_checker #(
  parameter int QUEUE_DEPTH = feab_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  localparam int CAP = 1 + QUEUE_DEPTH + feab_pkg::BACK_STAGES;

  logic [15:0] inflight_r;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output item valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != '0)
    else $error("output item without a pending input item");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    int'(inflight_r) <= CAP)
    else $error("more items in flight than the core can hold");

endmodule

bind feathered_edge_alpha_blend_core feab_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_feab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/tb_feathered_edge_alpha_blend_core.sv
// Self-checking testbench for the feathered edge alpha blend core.
`timescale 1ns / 1ps

module tb_feathered_edge_alpha_blend_core;

  localparam logic [feab_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int GAP_PCT = 16;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [3:0]                   pad;
    logic [feab_pkg::CH_W-1:0]    alpha;
    logic [feab_pkg::CH_W-1:0]    ch2;
    logic [feab_pkg::CH_W-1:0]    ch1;
    logic [feab_pkg::CH_W-1:0]    ch0;
    logic [feab_pkg::COORD_W-1:0] col;
    logic [feab_pkg::COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [feab_pkg::CH_W-1:0] ch2;
    logic [feab_pkg::CH_W-1:0] ch1;
    logic [feab_pkg::CH_W-1:0] ch0;
  } blended_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [55:0]                     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [23:0]                     out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [feab_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [feab_pkg::CFG_DATA_W-1:0] cfg_data;

  feab_pkg::cfg_t regs;
  pixel_t   pixel_q[$];
  blended_t blend_q[$];
  blended_t got_px;
  blended_t want_px;
  bit       steady = 1'b0;
  int       err_count = 0;

  feathered_edge_alpha_blend_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic logic [feab_pkg::CH_W-1:0] mix_channel(logic [63:0] w, logic [63:0] pix,
                                                            logic [63:0] tgt);
    logic [63:0] acc;
    acc = w * pix + (64'd65536 - w) * tgt + 64'd32768;
    return acc[23:16];
  endfunction

  function automatic blended_t blend_pixel(pixel_t p);
    logic [63:0] bw, d_bot, d_right, dmin, m, num, den, w;
    blended_t r;
    bw = (regs.border_width == 0) ? 64'd1 : 64'(regs.border_width);
    d_bot = (p.row >= regs.patch_height) ? 64'd0 : 64'(regs.patch_height) - 1 - 64'(p.row);
    d_right = (p.col >= regs.patch_width) ? 64'd0 : 64'(regs.patch_width) - 1 - 64'(p.col);
    dmin = (p.row < p.col) ? 64'(p.row) : 64'(p.col);
    if (d_bot < dmin) dmin = d_bot;
    if (d_right < dmin) dmin = d_right;
    m = (dmin < bw) ? dmin : bw;
    num = (bw - m) * 64'(regs.blend_percent) * 64'(p.alpha) * 64'd65536;
    den = bw * 64'd25500;
    w = num / den;
    if (w > 64'd65536) w = 64'd65536;
    r.ch0 = mix_channel(w, 64'(p.ch0), 64'(regs.target_ch0));
    r.ch1 = mix_channel(w, 64'(p.ch1), 64'(regs.target_ch1));
    r.ch2 = mix_channel(w, 64'(p.ch2), 64'(regs.target_ch2));
    return r;
  endfunction

  function automatic void shadow_write(logic [feab_pkg::CFG_IDX_W-1:0] idx,
                                       logic [feab_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      feab_pkg::CFG_BORDER_WIDTH:  regs.border_width = d;
      feab_pkg::CFG_BLEND_PERCENT:
        regs.blend_percent = (int'(d[feab_pkg::PCT_W-1:0]) > feab_pkg::PCT_MAX)
                             ? feab_pkg::PCT_W'(feab_pkg::PCT_MAX) : d[feab_pkg::PCT_W-1:0];
      feab_pkg::CFG_PATCH_WIDTH:
        regs.patch_width = (int'(d) > feab_pkg::MAX_SIDE)
                           ? feab_pkg::SIZE_W'(feab_pkg::MAX_SIDE) : d;
      feab_pkg::CFG_PATCH_HEIGHT:
        regs.patch_height = (int'(d) > feab_pkg::MAX_SIDE)
                            ? feab_pkg::SIZE_W'(feab_pkg::MAX_SIDE) : d;
      feab_pkg::CFG_TARGET_CH0:    regs.target_ch0 = d[feab_pkg::CH_W-1:0];
      feab_pkg::CFG_TARGET_CH1:    regs.target_ch1 = d[feab_pkg::CH_W-1:0];
      feab_pkg::CFG_TARGET_CH2:    regs.target_ch2 = d[feab_pkg::CH_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [feab_pkg::CH_W-1:0] want,
                             logic [feab_pkg::CH_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic write_reg(logic [feab_pkg::CFG_IDX_W-1:0] idx,
                           logic [feab_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_write(idx, d);
  endtask

  task automatic set_config(int bw, int pct, int pw, int ph, int t0, int t1, int t2);
    write_reg(feab_pkg::CFG_BORDER_WIDTH, feab_pkg::CFG_DATA_W'(bw));
    write_reg(feab_pkg::CFG_BLEND_PERCENT, feab_pkg::CFG_DATA_W'(pct));
    write_reg(feab_pkg::CFG_PATCH_WIDTH, feab_pkg::CFG_DATA_W'(pw));
    write_reg(feab_pkg::CFG_PATCH_HEIGHT, feab_pkg::CFG_DATA_W'(ph));
    write_reg(feab_pkg::CFG_TARGET_CH0, feab_pkg::CFG_DATA_W'(t0));
    write_reg(feab_pkg::CFG_TARGET_CH1, feab_pkg::CFG_DATA_W'(t1));
    write_reg(feab_pkg::CFG_TARGET_CH2, feab_pkg::CFG_DATA_W'(t2));
  endtask

  task automatic add_pixel(int row, int col, int c0, int c1, int c2, int a);
    pixel_t p;
    p       = '0;
    p.row   = feab_pkg::COORD_W'(row);
    p.col   = feab_pkg::COORD_W'(col);
    p.ch0   = feab_pkg::CH_W'(c0);
    p.ch1   = feab_pkg::CH_W'(c1);
    p.ch2   = feab_pkg::CH_W'(c2);
    p.alpha = feab_pkg::CH_W'(a);
    pixel_q.push_back(p);
  endtask

  // hold off until the pipe is empty, then let it settle
  task automatic drain();
    while (pixel_q.size() != 0 || in_tvalid || blend_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) blend_q.push_back(blend_pixel(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
          in_tdata  <= pixel_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (blend_q.size() == 0) begin
          $error("unexpected item: got %h", out_tdata);
          err_count++;
        end else begin
          got_px  = out_tdata;
          want_px = blend_q.pop_front();
          check_field("out_ch0", want_px.ch0, got_px.ch0);
          check_field("out_ch1", want_px.ch1, got_px.ch1);
          check_field("out_ch2", want_px.ch2, got_px.ch2);
        end
      end
      out_tready <= steady || ($urandom_range(99) >= GAP_PCT);
    end
  end

  initial begin
    int bw_v, pct_v, pw_v, ph_v, roll;
    pixel_t px;
    regs = '{border_width: 2, blend_percent: 30, patch_width: 64, patch_height: 64,
             target_ch0: 0, target_ch1: 0, target_ch2: 0};
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: edges, ramp, interior, outside the patch, alpha extremes
    add_pixel(0, 0, 255, 255, 255, 255);
    add_pixel(1, 1, 200, 100, 50, 255);
    add_pixel(2, 2, 200, 100, 50, 255);
    add_pixel(63, 63, 255, 0, 255, 255);
    add_pixel(63, 10, 90, 180, 30, 200);
    add_pixel(10, 63, 90, 180, 30, 200);
    add_pixel(1023, 1023, 255, 255, 255, 255);
    add_pixel(64, 5, 120, 7, 240, 255);
    add_pixel(0, 0, 255, 255, 255, 0);
    add_pixel(0, 0, 0, 0, 0, 255);
    add_pixel(5, 0, 8'hAA, 8'h55, 8'h0F, 128);
    drain();

    // zero border, percent clamp, width clamp, single-row patch
    set_config(0, 127, 2047, 1, 255, 0, 128);
    add_pixel(0, 0, 0, 255, 17, 255);
    add_pixel(0, 1023, 0, 255, 17, 255);
    add_pixel(0, 500, 33, 66, 99, 255);
    add_pixel(1, 5, 1, 2, 3, 77);
    drain();

    // oversized border, zero-width patch
    set_config(2047, 100, 0, 1024, 17, 200, 255);
    add_pixel(1023, 1023, 255, 0, 0, 255);
    add_pixel(512, 512, 0, 255, 0, 255);
    add_pixel(0, 300, 128, 128, 128, 1);
    drain();

    // zero strength, full-size patch
    set_config(1024, 0, 1024, 1024, 255, 255, 255);
    add_pixel(512, 512, 0, 0, 0, 255);
    add_pixel(0, 0, 0, 0, 0, 255);
    add_pixel(1023, 0, 12, 34, 56, 255);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(6))
        0: bw_v = 0;
        1: bw_v = 1;
        2: bw_v = 1024;
        3: bw_v = 2047;
        default: bw_v = $urandom_range(20, 2);
      endcase
      case ($urandom_range(4))
        0: pct_v = 0;
        1: pct_v = 100;
        2: pct_v = 127;
        3: pct_v = $urandom_range(2047);
        default: pct_v = $urandom_range(100);
      endcase
      case ($urandom_range(7))
        0: pw_v = 0;
        1: pw_v = 1;
        2: pw_v = 1024;
        3: pw_v = 2047;
        default: pw_v = $urandom_range(48, 2);
      endcase
      case ($urandom_range(7))
        0: ph_v = 0;
        1: ph_v = 1;
        2: ph_v = 1024;
        3: ph_v = 2047;
        default: ph_v = $urandom_range(48, 2);
      endcase
      set_config(bw_v, pct_v, pw_v, ph_v, $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
      write_reg(CFG_UNUSED, feab_pkg::CFG_DATA_W'($urandom_range(2047)));
      steady = (phase == 3);

      for (int i = 0; i < 50; i++) begin
        px = '0;
        px.row = feab_pkg::COORD_W'((regs.patch_height == 0 || $urandom_range(99) < 15)
                 ? $urandom_range(1023) : $urandom_range(regs.patch_height - 1));
        px.col = feab_pkg::COORD_W'((regs.patch_width == 0 || $urandom_range(99) < 15)
                 ? $urandom_range(1023) : $urandom_range(regs.patch_width - 1));
        px.ch0 = feab_pkg::CH_W'($urandom_range(255));
        px.ch1 = feab_pkg::CH_W'($urandom_range(255));
        px.ch2 = feab_pkg::CH_W'($urandom_range(255));
        roll = $urandom_range(9);
        px.alpha = (roll < 3) ? 8'd255 : (roll == 3) ? 8'd0 : 8'($urandom_range(255));
        pixel_q.push_back(px);
        if (i == 24) begin
          while (pixel_q.size() != 0 || in_tvalid || blend_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    steady = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && blend_q.size() == 0) begin
      $display("tb_feathered_edge_alpha_blend_core: done, clean");
    end else begin
      $display("tb_feathered_edge_alpha_blend_core: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_feathered_edge_alpha_blend_core: done, errors");
    $finish;
  end

endmodule
